### rtl/layer_alpha_compositor_defines.svh
// assertion macros for the layer alpha compositor
`ifndef LAYER_ALPHA_COMPOSITOR_DEFINES_SVH
`define LAYER_ALPHA_COMPOSITOR_DEFINES_SVH
`ifndef SYNTHESIS
`define LAC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lac property violated");
`define LAC_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("lac forbidden condition seen");
`else
`define LAC_ASSERT(lbl, prop)
`define LAC_ASSERT_NEVER(lbl, cond)
`endif
`endif

### rtl/lac_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers of the layer alpha compositor
package lac_pkg;

    localparam int MAX_LAYERS = 16;
    localparam int POS_W      = $clog2(MAX_LAYERS);
    localparam int DIV_W      = $clog2(MAX_LAYERS + 1);
    localparam int CHAN_W     = 32;
    localparam int ALPHA_W    = 17;
    localparam int Q_FRAC     = 16;
    localparam int ROUND_HALF = 32768;
    localparam int PROD_W     = CHAN_W + ALPHA_W + 1;
    localparam int AP_W       = 2 * ALPHA_W;
    localparam int NUM_CHAN   = 3;

    // reciprocal table precision for the blend divide
    localparam int RCP_SHIFT  = 18;
    localparam int RCP_W      = RCP_SHIFT + 1;

    // power of two so the pointers wrap on their own
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [ALPHA_W-1:0]       ONE_Q16       = ALPHA_W'(65536);
    localparam logic [POS_W-1:0]         POS_MAX       = POS_W'(MAX_LAYERS - 1);
    localparam logic [CNT_W-1:0]         FIFO_FULL_CNT = CNT_W'(FIFO_DEPTH);
    localparam logic signed [CHAN_W-1:0] CHAN_MAX      = {1'b0, {(CHAN_W-1){1'b1}}};
    localparam logic signed [CHAN_W-1:0] CHAN_MIN      = {1'b1, {(CHAN_W-1){1'b0}}};

    typedef struct packed {
        logic signed [CHAN_W-1:0] x;
        logic signed [CHAN_W-1:0] y;
        logic signed [CHAN_W-1:0] z;
        logic [ALPHA_W-1:0]       alpha;
        logic                     first_layer;
        logic                     last_layer;
    } t_layer;

    typedef struct packed {
        logic signed [CHAN_W-1:0] x;
        logic signed [CHAN_W-1:0] y;
        logic signed [CHAN_W-1:0] z;
        logic [ALPHA_W-1:0]       alpha;
    } t_pixel;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_FIX, F_PUSH} t_front_state;
    typedef enum logic [1:0] {B_IDLE, B_MUL, B_FIN} t_back_state;

    function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
        return (a > ONE_Q16) ? ONE_Q16 : a;
    endfunction

    function automatic logic [DIV_W-1:0] pos_to_div(input logic [POS_W-1:0] pos);
        return DIV_W'(pos) + DIV_W'(1);
    endfunction

    function automatic logic [ALPHA_W-1:0] div_to_alpha_w(input logic [DIV_W-1:0] d);
        return ALPHA_W'(d);
    endfunction

    // floor((v + 2^15) / 2^16)
    function automatic logic signed [CHAN_W:0] round_q16(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] w;
        w = v + PROD_W'(ROUND_HALF);
        return w[Q_FRAC +: CHAN_W+1];
    endfunction

    function automatic logic signed [CHAN_W-1:0] sat_chan(input logic signed [CHAN_W:0] v);
        if (v[CHAN_W] != v[CHAN_W-1]) begin
            return v[CHAN_W] ? CHAN_MIN : CHAN_MAX;
        end
        return v[CHAN_W-1:0];
    endfunction

    // round(acc_alpha * (1 - a)) + a, saturated to one
    function automatic logic [ALPHA_W-1:0] alpha_next(input logic [AP_W-1:0] p,
                                                      input logic [ALPHA_W-1:0] a);
        logic [AP_W-1:0]    w;
        logic [ALPHA_W+1:0] s;
        w = p + AP_W'(ROUND_HALF);
        s = (ALPHA_W+2)'(w[AP_W-1:Q_FRAC]) + (ALPHA_W+2)'(a);
        return (s > (ALPHA_W+2)'(ONE_Q16)) ? ONE_Q16 : s[ALPHA_W-1:0];
    endfunction

endpackage

### rtl/lac_fifo.sv
`timescale 1ns / 1ps
// short item queue between the front and the back
module lac_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  lac_pkg::t_layer     i_wr_item,
    input  logic                i_rd,
    output lac_pkg::t_layer     o_head,
    output lac_pkg::t_fifo_stat o_stat
);

    lac_pkg::t_layer                r_mem [lac_pkg::FIFO_DEPTH];
    logic [lac_pkg::PTR_W-1:0]      r_wptr;
    logic [lac_pkg::PTR_W-1:0]      r_rptr;
    logic [lac_pkg::CNT_W-1:0]      r_count;
    logic [lac_pkg::CNT_W-1:0]      n_count;

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wr_item;
        end
    end

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == lac_pkg::FIFO_FULL_CNT);
    assign o_stat.empty = (r_count == '0);

endmodule

### rtl/lac_front.sv
`timescale 1ns / 1ps
// front end: takes layer items, tracks position, scales alpha in blend mode
`include "layer_alpha_compositor_defines.svh"
module lac_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  lac_pkg::t_layer     i_item,
    input  logic                i_blend_mode,
    input  lac_pkg::t_fifo_stat i_fifo_stat,
    output logic                o_wr,
    output lac_pkg::t_layer     o_wr_item
);

    lac_pkg::t_front_state                         r_state;
    lac_pkg::t_front_state                         n_state;
    lac_pkg::t_layer                               r_item;
    lac_pkg::t_layer                               n_item;
    logic [lac_pkg::POS_W-1:0]                     r_pos;
    logic [lac_pkg::POS_W-1:0]                     n_pos;
    logic [lac_pkg::RCP_W+lac_pkg::ALPHA_W-1:0]    r_prod;
    logic [lac_pkg::RCP_W+lac_pkg::ALPHA_W-1:0]    n_prod;
    logic [lac_pkg::RCP_W-1:0]                     w_rcp [lac_pkg::MAX_LAYERS];
    logic [lac_pkg::DIV_W-1:0]                     w_div;
    logic [lac_pkg::ALPHA_W-1:0]                   w_q0;
    logic [lac_pkg::ALPHA_W+lac_pkg::DIV_W-1:0]    w_qd;
    logic [lac_pkg::ALPHA_W-1:0]                   w_rem;

    // reciprocal of (position + 1), scaled by 2^RCP_SHIFT
    for (genvar g = 0; g < lac_pkg::MAX_LAYERS; g++) begin : g_rcp
        localparam int RCP = (1 << lac_pkg::RCP_SHIFT) / (g + 1);
        assign w_rcp[g] = RCP[lac_pkg::RCP_W-1:0];
    end

    // estimate is exact or one low, one compare fixes it
    assign w_div = lac_pkg::pos_to_div(r_pos);
    assign w_q0  = r_prod[lac_pkg::RCP_SHIFT +: lac_pkg::ALPHA_W];
    assign w_qd  = w_q0 * w_div;
    assign w_rem = r_item.alpha - w_qd[lac_pkg::ALPHA_W-1:0];

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_pos   = r_pos;
        n_prod  = r_prod;
        o_wr    = 1'b0;
        full    = 1'b1;
        case (r_state)
            lac_pkg::F_IDLE: begin
                full = 1'b0;
                if (push) begin
                    n_item       = i_item;
                    n_item.alpha = lac_pkg::clamp_alpha(i_item.alpha);
                    if (i_item.first_layer) begin
                        n_pos = '0;
                    end else if (r_pos != lac_pkg::POS_MAX) begin
                        n_pos = r_pos + 1'b1;
                    end
                    if (!i_item.first_layer && i_blend_mode) begin
                        n_state = lac_pkg::F_MUL;
                    end else begin
                        n_state = lac_pkg::F_PUSH;
                    end
                end
            end
            lac_pkg::F_MUL: begin
                n_prod  = r_item.alpha * w_rcp[r_pos];
                n_state = lac_pkg::F_FIX;
            end
            lac_pkg::F_FIX: begin
                if (w_rem >= lac_pkg::div_to_alpha_w(w_div)) begin
                    n_item.alpha = w_q0 + 1'b1;
                end else begin
                    n_item.alpha = w_q0;
                end
                n_state = lac_pkg::F_PUSH;
            end
            lac_pkg::F_PUSH: begin
                if (!i_fifo_stat.full) begin
                    o_wr    = 1'b1;
                    n_state = lac_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = lac_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lac_pkg::F_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_prod <= n_prod;
    end

    assign o_wr_item = r_item;

    `LAC_ASSERT_NEVER(a_pos_range, r_pos > lac_pkg::POS_MAX)
    `LAC_ASSERT(a_wr_room, o_wr |-> !i_fifo_stat.full)
    `LAC_ASSERT(a_div_shrinks, (r_state == lac_pkg::F_PUSH && $past(r_state) == lac_pkg::F_FIX) |-> r_item.alpha <= $past(r_item.alpha))

endmodule

### rtl/lac_back.sv
`timescale 1ns / 1ps
// back end: compositing datapath, accumulator and result register
`include "layer_alpha_compositor_defines.svh"
module lac_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lac_pkg::t_fifo_stat i_fifo_stat,
    input  lac_pkg::t_layer     i_head,
    output logic                o_rd,
    input  logic                pop,
    output logic                empty,
    output lac_pkg::t_pixel     o_pixel
);

    lac_pkg::t_back_state                r_state;
    lac_pkg::t_back_state                n_state;
    lac_pkg::t_layer                     r_item;
    lac_pkg::t_layer                     n_item;
    logic signed [lac_pkg::CHAN_W-1:0]   r_acc        [lac_pkg::NUM_CHAN];
    logic signed [lac_pkg::CHAN_W-1:0]   n_acc        [lac_pkg::NUM_CHAN];
    logic [lac_pkg::ALPHA_W-1:0]         r_acc_alpha;
    logic [lac_pkg::ALPHA_W-1:0]         n_acc_alpha;
    logic signed [lac_pkg::PROD_W-1:0]   r_prod_acc   [lac_pkg::NUM_CHAN];
    logic signed [lac_pkg::PROD_W-1:0]   n_prod_acc   [lac_pkg::NUM_CHAN];
    logic signed [lac_pkg::PROD_W-1:0]   r_prod_t     [lac_pkg::NUM_CHAN];
    logic signed [lac_pkg::PROD_W-1:0]   n_prod_t     [lac_pkg::NUM_CHAN];
    logic signed [lac_pkg::PROD_W-1:0]   r_prod_l     [lac_pkg::NUM_CHAN];
    logic signed [lac_pkg::PROD_W-1:0]   n_prod_l     [lac_pkg::NUM_CHAN];
    logic [lac_pkg::AP_W-1:0]            r_prod_alpha;
    logic [lac_pkg::AP_W-1:0]            n_prod_alpha;
    lac_pkg::t_pixel                     r_out;
    lac_pkg::t_pixel                     n_out;
    logic                                r_out_valid;
    logic                                n_out_valid;

    logic signed [lac_pkg::CHAN_W-1:0]   w_head_layer [lac_pkg::NUM_CHAN];
    logic signed [lac_pkg::CHAN_W-1:0]   w_item_layer [lac_pkg::NUM_CHAN];
    logic signed [lac_pkg::CHAN_W:0]     w_t_full     [lac_pkg::NUM_CHAN];
    logic signed [lac_pkg::CHAN_W-1:0]   w_t          [lac_pkg::NUM_CHAN];
    logic signed [lac_pkg::CHAN_W-1:0]   w_new        [lac_pkg::NUM_CHAN];
    logic [lac_pkg::ALPHA_W-1:0]         w_new_alpha;
    logic [lac_pkg::ALPHA_W-1:0]         w_inv_head;
    logic [lac_pkg::ALPHA_W-1:0]         w_inv_item;
    logic                                w_out_free;

    assign w_head_layer[0] = i_head.x;
    assign w_head_layer[1] = i_head.y;
    assign w_head_layer[2] = i_head.z;
    assign w_item_layer[0] = r_item.x;
    assign w_item_layer[1] = r_item.y;
    assign w_item_layer[2] = r_item.z;

    assign w_inv_head = lac_pkg::ONE_Q16 - i_head.alpha;
    assign w_inv_item = lac_pkg::ONE_Q16 - r_item.alpha;
    assign w_out_free = !r_out_valid || pop;

    for (genvar c = 0; c < lac_pkg::NUM_CHAN; c++) begin : g_lane
        assign w_t_full[c] = lac_pkg::round_q16(r_prod_acc[c]);
        assign w_t[c]      = w_t_full[c][lac_pkg::CHAN_W-1:0];
        assign w_new[c]    = lac_pkg::sat_chan(lac_pkg::round_q16(r_prod_t[c] + r_prod_l[c]));
    end

    assign w_new_alpha = lac_pkg::alpha_next(r_prod_alpha, r_item.alpha);

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_acc        = r_acc;
        n_acc_alpha  = r_acc_alpha;
        n_prod_acc   = r_prod_acc;
        n_prod_t     = r_prod_t;
        n_prod_l     = r_prod_l;
        n_prod_alpha = r_prod_alpha;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !pop;
        o_rd         = 1'b0;
        case (r_state)
            lac_pkg::B_IDLE: begin
                if (!i_fifo_stat.empty) begin
                    if (i_head.first_layer) begin
                        if (!i_head.last_layer || w_out_free) begin
                            o_rd        = 1'b1;
                            n_acc       = w_head_layer;
                            n_acc_alpha = i_head.alpha;
                            if (i_head.last_layer) begin
                                n_out.x     = i_head.x;
                                n_out.y     = i_head.y;
                                n_out.z     = i_head.z;
                                n_out.alpha = i_head.alpha;
                                n_out_valid = 1'b1;
                            end
                        end
                    end else begin
                        o_rd   = 1'b1;
                        n_item = i_head;
                        for (int i = 0; i < lac_pkg::NUM_CHAN; i++) begin
                            n_prod_acc[i] = r_acc[i] * $signed({1'b0, r_acc_alpha});
                        end
                        n_prod_alpha = r_acc_alpha * w_inv_head;
                        n_state      = lac_pkg::B_MUL;
                    end
                end
            end
            lac_pkg::B_MUL: begin
                for (int i = 0; i < lac_pkg::NUM_CHAN; i++) begin
                    n_prod_t[i] = w_t[i] * $signed({1'b0, w_inv_item});
                    n_prod_l[i] = w_item_layer[i] * $signed({1'b0, r_item.alpha});
                end
                n_state = lac_pkg::B_FIN;
            end
            lac_pkg::B_FIN: begin
                if (!r_item.last_layer || w_out_free) begin
                    n_acc       = w_new;
                    n_acc_alpha = w_new_alpha;
                    if (r_item.last_layer) begin
                        n_out.x     = w_new[0];
                        n_out.y     = w_new[1];
                        n_out.z     = w_new[2];
                        n_out.alpha = w_new_alpha;
                        n_out_valid = 1'b1;
                    end
                    n_state = lac_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = lac_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lac_pkg::B_IDLE;
            r_out_valid <= 1'b0;
            r_acc_alpha <= '0;
            for (int i = 0; i < lac_pkg::NUM_CHAN; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_acc_alpha <= n_acc_alpha;
            r_acc       <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_prod_acc   <= n_prod_acc;
        r_prod_t     <= n_prod_t;
        r_prod_l     <= n_prod_l;
        r_prod_alpha <= n_prod_alpha;
        r_out        <= n_out;
    end

    assign empty   = !r_out_valid;
    assign o_pixel = r_out;

    `LAC_ASSERT_NEVER(a_alpha_range, r_acc_alpha > lac_pkg::ONE_Q16)
    `LAC_ASSERT(a_rd_idle, o_rd |-> (r_state == lac_pkg::B_IDLE && !i_fifo_stat.empty))
    `LAC_ASSERT(a_mul_to_fin, (r_state == lac_pkg::B_MUL) |=> (r_state == lac_pkg::B_FIN))

endmodule

### rtl/layer_alpha_compositor.sv
`timescale 1ns / 1ps
// layer alpha compositor top: front end, item queue, compositing back end
// front takes a new item only after the last one is written to the queue; it waits while the queue is full
// in blend mode an upper layer also passes through a multiply state and a fix state for the divide
// back takes a bottom layer straight from the queue; an upper layer goes through idle, multiply and finish
// states (two chained multiplies + commit); a last layer waits in its state while the result is not popped
// reset: synchronous active low, clears accumulator, layer position, queue and blend_mode
module layer_alpha_compositor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // layer item channel
    input  logic                               push,
    output logic                               full,
    input  logic signed [lac_pkg::CHAN_W-1:0]  i_chan_x,
    input  logic signed [lac_pkg::CHAN_W-1:0]  i_chan_y,
    input  logic signed [lac_pkg::CHAN_W-1:0]  i_chan_z,
    input  logic [lac_pkg::ALPHA_W-1:0]        i_layer_alpha,
    input  logic                               i_first_layer,
    input  logic                               i_last_layer,
    // result item channel
    output logic                               empty,
    input  logic                               pop,
    output logic signed [lac_pkg::CHAN_W-1:0]  o_out_x,
    output logic signed [lac_pkg::CHAN_W-1:0]  o_out_y,
    output logic signed [lac_pkg::CHAN_W-1:0]  o_out_z,
    output logic [lac_pkg::ALPHA_W-1:0]        o_out_alpha,
    // blend_mode register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data
);

    logic                r_blend_mode;
    lac_pkg::t_layer     w_in_item;
    lac_pkg::t_layer     w_wr_item;
    lac_pkg::t_layer     w_head;
    lac_pkg::t_fifo_stat w_fifo_stat;
    lac_pkg::t_pixel     w_pixel;
    logic                w_wr;
    logic                w_rd;

    // register write is always taken; user writes only while the block is idle, which it does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_blend_mode <= i_cfg_data;
        end
    end

    // pack the item fields for the front end
    assign w_in_item.x           = i_chan_x;
    assign w_in_item.y           = i_chan_y;
    assign w_in_item.z           = i_chan_z;
    assign w_in_item.alpha       = i_layer_alpha;
    assign w_in_item.first_layer = i_first_layer;
    assign w_in_item.last_layer  = i_last_layer;

    // front: alpha clamp, layer position, blend-mode divide by position + 1
    lac_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_item       (w_in_item),
        .i_blend_mode (r_blend_mode),
        .i_fifo_stat  (w_fifo_stat),
        .o_wr         (w_wr),
        .o_wr_item    (w_wr_item)
    );

    // queue lets front and back stall independently
    lac_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_wr_item (w_wr_item),
        .i_rd      (w_rd),
        .o_head    (w_head),
        .o_stat    (w_fifo_stat)
    );

    // back: accumulator update and result register
    lac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo_stat (w_fifo_stat),
        .i_head      (w_head),
        .o_rd        (w_rd),
        .pop         (pop),
        .empty       (empty),
        .o_pixel     (w_pixel)
    );

    assign o_out_x     = w_pixel.x;
    assign o_out_y     = w_pixel.y;
    assign o_out_z     = w_pixel.z;
    assign o_out_alpha = w_pixel.alpha;

endmodule

### tb/layer_alpha_compositor_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the layer alpha compositor with its own compositing predictor
module layer_alpha_compositor_test;

    import lac_pkg::*;

    // Q1.16 one, and cycles allowed for items that end in no result to clear the block
    localparam longint UNITY          = 65536;
    localparam int     SETTLE_CYCLES  = 40;
    localparam int     WATCHDOG_LIMIT = 3000;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     PHASE_ITEMS    = 400;
    localparam int     REPORT_LIMIT   = 10;

    // every input of the block starts at a known value
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      push          = 1'b0;
    logic                      full;
    logic signed [CHAN_W-1:0]  i_chan_x      = '0;
    logic signed [CHAN_W-1:0]  i_chan_y      = '0;
    logic signed [CHAN_W-1:0]  i_chan_z      = '0;
    logic [ALPHA_W-1:0]        i_layer_alpha = '0;
    logic                      i_first_layer = 1'b0;
    logic                      i_last_layer  = 1'b0;
    logic                      empty;
    logic                      pop           = 1'b0;
    logic signed [CHAN_W-1:0]  o_out_x;
    logic signed [CHAN_W-1:0]  o_out_y;
    logic signed [CHAN_W-1:0]  o_out_z;
    logic [ALPHA_W-1:0]        o_out_alpha;
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic                      i_cfg_data    = 1'b0;

    // predictor state: running composite of the current pixel stack
    longint sum_x     = 0;
    longint sum_y     = 0;
    longint sum_z     = 0;
    longint sum_alpha = 0;
    int     stack_pos = 0;
    bit     blend_on  = 1'b0;

    // composited pixels still owed by the block, oldest first
    t_pixel pending_pixels[$];

    int mismatch_count = 0;
    int stall_cycles   = 0;
    int send_gap_pct   = 0;
    int pop_stall_pct  = 0;
    bit rx_hold        = 1'b0;

    layer_alpha_compositor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_chan_x      (i_chan_x),
        .i_chan_y      (i_chan_y),
        .i_chan_z      (i_chan_z),
        .i_layer_alpha (i_layer_alpha),
        .i_first_layer (i_first_layer),
        .i_last_layer  (i_last_layer),
        .empty         (empty),
        .pop           (pop),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_out_alpha   (o_out_alpha),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // compositing predictor
    // ---------------------------------------------------------------

    // q16 rescale, half rounds toward plus infinity (arithmetic shift floors)
    function automatic longint round_half_up(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip_chan(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // the over step as the pipeline does it: accumulated colour is weighted
    // by the accumulated alpha again before the (1 - a) term
    function automatic longint over_blend(input longint acc, input longint layer,
                                          input longint a);
        longint weighted;
        weighted = round_half_up(acc * sum_alpha);
        return clip_chan(round_half_up(weighted * (UNITY - a) + layer * a));
    endfunction

    function automatic void composite_layer(input longint x, input longint y,
                                            input longint z, input longint alpha,
                                            input bit is_bottom, input bit is_top);
        longint a;
        longint next_alpha;
        t_pixel px;
        a = (alpha > UNITY) ? UNITY : alpha;
        if (is_bottom) begin
            // bottom layer seeds the stack
            sum_x     = x;
            sum_y     = y;
            sum_z     = z;
            sum_alpha = a;
            stack_pos = 0;
        end else begin
            // position stops growing at the deepest supported layer
            if (stack_pos < MAX_LAYERS - 1) stack_pos++;
            if (blend_on) a = a / (stack_pos + 1);
            sum_x = over_blend(sum_x, x, a);
            sum_y = over_blend(sum_y, y, a);
            sum_z = over_blend(sum_z, z, a);
            next_alpha = round_half_up(sum_alpha * (UNITY - a)) + a;
            sum_alpha  = (next_alpha > UNITY) ? UNITY : next_alpha;
        end
        if (is_top) begin
            px.x     = sum_x[CHAN_W-1:0];
            px.y     = sum_y[CHAN_W-1:0];
            px.z     = sum_z[CHAN_W-1:0];
            px.alpha = sum_alpha[ALPHA_W-1:0];
            pending_pixels.push_back(px);
        end
    endfunction

    // ---------------------------------------------------------------
    // monitor: predicts on every accepted layer, checks every popped pixel
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_pixel want;
        t_pixel got;
        if (i_rst_n) begin
            // a popped pixel is compared with the oldest prediction
            if (pop && !empty) begin
                got.x     = o_out_x;
                got.y     = o_out_y;
                got.z     = o_out_z;
                got.alpha = o_out_alpha;
                if (pending_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected pixel x=%0d y=%0d z=%0d a=%0d",
                                 got.x, got.y, got.z, got.alpha);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.x !== want.x || got.y !== want.y ||
                        got.z !== want.z || got.alpha !== want.alpha) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("pixel mismatch exp x=%0d y=%0d z=%0d a=%0d got x=%0d y=%0d z=%0d a=%0d",
                                     want.x, want.y, want.z, want.alpha,
                                     got.x, got.y, got.z, got.alpha);
                    end
                end
            end
            // mode register write
            if (i_cfg_valid && o_cfg_ready)
                blend_on = i_cfg_data;
            // accepted layer item
            if (push && !full)
                composite_layer(longint'(i_chan_x), longint'(i_chan_y), longint'(i_chan_z),
                                longint'(i_layer_alpha), i_first_layer, i_last_layer);
        end
    end

    // receiver: random stalls, or a solid hold-off when requested
    always @(posedge i_clk) begin
        if (rx_hold)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // watchdog on cycles in which no handshake completes
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[layer_alpha_compositor] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic signed [CHAN_W-1:0] pick_chan();
        case ($urandom_range(7))
            0: return CHAN_MAX;
            1: return CHAN_MIN;
            2: return '0;
            3: return CHAN_W'($signed($urandom_range(131071)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // alpha spans zero, opaque, values above one and the whole 17-bit field
    function automatic logic [ALPHA_W-1:0] pick_alpha();
        case ($urandom_range(7))
            0: return '0;
            1: return ONE_Q16;
            2: return '1;
            3: return ALPHA_W'($urandom_range(131071));
            default: return ALPHA_W'($urandom_range(65536));
        endcase
    endfunction

    // offer one layer item and hold it until the block takes it;
    // push stays high afterwards so back-to-back items need no toggle
    task automatic offer_layer(input logic signed [CHAN_W-1:0] x,
                               input logic signed [CHAN_W-1:0] y,
                               input logic signed [CHAN_W-1:0] z,
                               input logic [ALPHA_W-1:0] alpha,
                               input bit is_bottom, input bit is_top);
        while ($urandom_range(99) < send_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_chan_x      <= x;
        i_chan_y      <= y;
        i_chan_z      <= z;
        i_layer_alpha <= alpha;
        i_first_layer <= is_bottom;
        i_last_layer  <= is_top;
        do @(posedge i_clk); while (!(push && !full));
    endtask

    task automatic send_pixel(input int depth);
        for (int i = 0; i < depth; i++)
            offer_layer(pick_chan(), pick_chan(), pick_chan(), pick_alpha(),
                        i == 0, i == depth - 1);
    endtask

    // stop sending, wait for every owed pixel, then let layers with no result clear
    task automatic drain_pipeline();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_blend_mode(input bit mode);
        drain_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic hold_receiver(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // extremes, clamped alpha, unseeded layers and single-layer pixels in plain mode
    task automatic test_directed_layers();
        write_blend_mode(1'b0);
        // upper layer straight after reset, alpha far above one
        offer_layer(CHAN_MAX, CHAN_MIN, -32'sd1, '1, 1'b0, 1'b1);
        // single-layer pixel, transparent
        offer_layer(CHAN_MIN, CHAN_MAX, '0, '0, 1'b1, 1'b1);
        // upper layer right after a result, no emit
        offer_layer(32'sd12345, -32'sd1, CHAN_MAX, ONE_Q16, 1'b0, 1'b0);
        offer_layer(CHAN_MIN, CHAN_MIN, CHAN_MIN, 17'd32768, 1'b0, 1'b1);
        // seeded stack of three, opaque bottom
        offer_layer(CHAN_MAX, CHAN_MAX, CHAN_MAX, ONE_Q16, 1'b1, 1'b0);
        offer_layer(CHAN_MAX, CHAN_MIN, 32'sd65536, 17'd1, 1'b0, 1'b0);
        offer_layer(32'sd65536, -32'sd65536, 32'sd32767, 17'd65535, 1'b0, 1'b1);
        // single-layer pixel, alpha just above one
        offer_layer(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_F0F0, 17'd65537, 1'b1, 1'b1);
    endtask

    // blend mode on a stack deeper than the position counter allows
    task automatic test_blend_deep_stack();
        logic [ALPHA_W-1:0] a;
        write_blend_mode(1'b1);
        for (int i = 0; i < 18; i++) begin
            case (i % 3)
                0: a = ONE_Q16;
                1: a = '1;
                default: a = 17'd40000;
            endcase
            // emit midway as well, the stack keeps going without a new seed
            offer_layer((i % 2) ? CHAN_MAX : CHAN_MIN, (i % 2) ? CHAN_MIN : CHAN_MAX,
                        32'(i * 70000), a, i == 0, i == 9 || i == 17);
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input backs up
    task automatic test_output_backpressure();
        int sent;
        int depth;
        send_gap_pct  = 0;
        pop_stall_pct <= 0;
        sent = 0;
        fork
            hold_receiver(HOLD_CYCLES);
        join_none
        while (sent < 24) begin
            depth = $urandom_range(3, 1);
            send_pixel(depth);
            sent += depth;
        end
        // sender pauses until every owed pixel has come out
        drain_pipeline();
    endtask

    // mostly well-formed pixel stacks with random content, some stray layers
    task automatic run_random_phase(input bit mode, input int gap_pct, input int stall_pct);
        int sent;
        int depth;
        write_blend_mode(mode);
        send_gap_pct  = gap_pct;
        pop_stall_pct <= stall_pct;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            if ($urandom_range(9) == 0) begin
                offer_layer(pick_chan(), pick_chan(), pick_chan(), pick_alpha(),
                            $urandom_range(1), $urandom_range(1));
                sent++;
            end else begin
                depth = ($urandom_range(9) == 0) ? $urandom_range(20, 6) : $urandom_range(5, 1);
                send_pixel(depth);
                sent += depth;
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(1'b0, 0, 0);
        run_random_phase(1'b1, 63, 0);
        run_random_phase(1'b0, 0, 63);
        run_random_phase(1'b1, 10, 10);
        send_gap_pct  = 0;
        pop_stall_pct <= 0;
    endtask

    initial begin
        apply_reset();
        test_directed_layers();
        test_blend_deep_stack();
        test_output_backpressure();
        test_random_traffic();
        drain_pipeline();
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("[layer_alpha_compositor] OK");
        else
            $display("[layer_alpha_compositor] ERROR");
        $finish;
    end

endmodule
